// ===== sv/cross_correlation_phase_meter_defines.svh =====
// Assertion macros used by the top module of the phase meter.
`ifndef CROSS_CORRELATION_PHASE_METER_DEFINES_SVH
`define CROSS_CORRELATION_PHASE_METER_DEFINES_SVH

`ifndef SYNTHESIS
`define CXPM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CXPM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CXPM_ASSERT(lbl, clk, rst, prop, msg)
`define CXPM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== sv/cxpm_pkg.sv =====
package cxpm_pkg;

   localparam int FRAME_LENGTH = 256;
   localparam int ADDR_W       = $clog2(FRAME_LENGTH);
   localparam int LAG_COUNT    = 2 * FRAME_LENGTH - 1;
   localparam int LAG_CNT_W    = $clog2(LAG_COUNT);
   localparam int LAG_W        = $clog2(FRAME_LENGTH) + 1;

   localparam int SAMPLE_W     = 16;
   localparam int PROD_W       = 2 * SAMPLE_W;
   localparam int ACC_W        = 48;
   localparam int DPL_W        = 24;
   localparam int PHASE_W      = 32;
   localparam int PEAK_W       = 9;
   localparam int PH_W         = LAG_W + DPL_W + 1;
   localparam int RND_W        = PH_W + 1;
   localparam int SAT_W        = 64;

   // Control that travels with each product through the correlation pipeline.
   typedef struct packed {
      logic                 valid;
      logic                 last;
      logic [LAG_CNT_W-1:0] lag_idx;
   } cxpm_mac_ctl_type;

endpackage

// ===== sv/cross_correlation_phase_meter.sv =====
// Channel   Handshake                   Payload
// req       start / busy                req_sample_a, req_sample_b
// rsp       rsp_valid (one-cycle pulse) rsp_phase_deg_q8, rsp_phase_updated, rsp_peak_lag
// csr       csr_valid / csr_ready       csr_wdata (degrees per lag, Q16)
//
// An item that does not complete a frame leaves busy low; its result is shown in the next cycle.
// The item that completes a frame keeps busy high while one multiply-accumulate reads one
// entry of each frame buffer per cycle for every lag; then the phase is scaled in S_MUL and
// rounded and saturated in S_RND.
// Reset clears the write position, held phase, held lag and register; buffers are not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
`include "cross_correlation_phase_meter_defines.svh"

module cross_correlation_phase_meter
   import cxpm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [SAMPLE_W-1:0] req_sample_a,
   input  logic [SAMPLE_W-1:0] req_sample_b,
   output logic                rsp_valid,
   output logic [PHASE_W-1:0]  rsp_phase_deg_q8,
   output logic                rsp_phase_updated,
   output logic [PEAK_W-1:0]   rsp_peak_lag,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [DPL_W-1:0]    csr_wdata
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_CORR  = 5'b00010,
      S_DRAIN = 5'b00100,
      S_MUL   = 5'b01000,
      S_RND   = 5'b10000
   } state_type;

   localparam logic [ADDR_W-1:0]    ADDR_LAST = ADDR_W'(FRAME_LENGTH - 1);
   localparam logic [LAG_CNT_W-1:0] IDX_LAST  = LAG_CNT_W'(LAG_COUNT - 1);
   localparam logic [LAG_CNT_W-1:0] IDX_ZERO  = LAG_CNT_W'(FRAME_LENGTH - 1);

   state_type             state_ff, state_in;
   logic [ADDR_W-1:0]     wr_pos_ff, wr_pos_in;
   logic [ADDR_W-1:0]     k_ff, k_in;
   logic [ADDR_W-1:0]     n_ff, n_in;
   logic [LAG_CNT_W-1:0]  lag_ff, lag_in;
   cxpm_mac_ctl_type      ctl1_ff, ctl1_in;
   logic [DPL_W-1:0]      dpl_ff, dpl_in;
   logic signed [PH_W-1:0] prod_ph_ff, prod_ph_in;
   logic [PHASE_W-1:0]    held_phase_ff, held_phase_in;
   logic [PEAK_W-1:0]     held_lag_ff, held_lag_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  updated_ff, updated_in;

   logic                  accept;
   logic                  accept_last;
   logic                  term_last;
   logic [LAG_CNT_W-1:0]  lag_nx;
   logic [SAMPLE_W-1:0]   a_rdata, b_rdata;
   logic                  mac_pending;
   logic [LAG_CNT_W-1:0]  best_idx;
   logic [LAG_CNT_W:0]    lag_wide;
   logic signed [LAG_W-1:0] peak_lag_s;
   logic signed [SAT_W-1:0] lag_ext;
   logic signed [RND_W-1:0] rnd_sum;
   logic signed [SAT_W-1:0] q_wide;
   logic                  q_fits;

   assign busy        = (state_ff != S_IDLE);
   assign accept      = start && !busy;
   assign accept_last = accept && (wr_pos_ff == ADDR_LAST);
   assign term_last   = (k_ff == ADDR_LAST) || (n_ff == ADDR_LAST);
   assign lag_nx      = lag_ff + LAG_CNT_W'(1);
   assign csr_ready   = 1'b1;

   // Lag index i stands for lag i - (FRAME_LENGTH - 1).
   assign lag_wide   = {1'b0, best_idx} - (LAG_CNT_W + 1)'(FRAME_LENGTH - 1);
   assign peak_lag_s = LAG_W'(lag_wide);
   assign lag_ext    = SAT_W'(peak_lag_s);

   // Round to nearest with ties away from zero, then saturate to 32 bits.
   assign rnd_sum = RND_W'(prod_ph_ff)
                  + (prod_ph_ff[PH_W-1] ? RND_W'(127) : RND_W'(128));
   assign q_wide  = SAT_W'(rnd_sum) >>> 8;
   assign q_fits  = (&q_wide[SAT_W-1:PHASE_W-1]) || !(|q_wide[SAT_W-1:PHASE_W-1]);

   always_comb begin
      state_in      = state_ff;
      wr_pos_in     = wr_pos_ff;
      k_in          = k_ff;
      n_in          = n_ff;
      lag_in        = lag_ff;
      ctl1_in       = '0;
      dpl_in        = dpl_ff;
      prod_ph_in    = prod_ph_ff;
      held_phase_in = held_phase_ff;
      held_lag_in   = held_lag_ff;
      rsp_valid_in  = 1'b0;
      updated_in    = 1'b0;

      if (csr_valid && csr_ready) begin
         dpl_in = csr_wdata;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (accept_last) begin
                  wr_pos_in = '0;
                  k_in      = '0;
                  n_in      = ADDR_LAST;
                  lag_in    = '0;
                  state_in  = S_CORR;
               end else begin
                  wr_pos_in    = wr_pos_ff + ADDR_W'(1);
                  rsp_valid_in = 1'b1;
               end
            end
         end
         S_CORR: begin
            ctl1_in.valid   = 1'b1;
            ctl1_in.last    = term_last;
            ctl1_in.lag_idx = lag_ff;
            if (term_last) begin
               if (lag_ff == IDX_LAST) begin
                  state_in = S_DRAIN;
               end else begin
                  lag_in = lag_nx;
                  if (lag_nx < IDX_ZERO) begin
                     k_in = '0;
                     n_in = ADDR_W'(IDX_ZERO - lag_nx);
                  end else begin
                     k_in = ADDR_W'(lag_nx - IDX_ZERO);
                     n_in = '0;
                  end
               end
            end else begin
               k_in = k_ff + ADDR_W'(1);
               n_in = n_ff + ADDR_W'(1);
            end
         end
         S_DRAIN: begin
            if (!ctl1_ff.valid && !mac_pending) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_ph_in = peak_lag_s * $signed({1'b0, dpl_ff});
            state_in   = S_RND;
         end
         S_RND: begin
            if (q_fits) begin
               held_phase_in = PHASE_W'(q_wide);
            end else if (q_wide[SAT_W-1]) begin
               held_phase_in = {1'b1, {(PHASE_W-1){1'b0}}};
            end else begin
               held_phase_in = {1'b0, {(PHASE_W-1){1'b1}}};
            end
            held_lag_in  = lag_ext[PEAK_W-1:0];
            rsp_valid_in = 1'b1;
            updated_in   = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         wr_pos_ff     <= '0;
         ctl1_ff       <= '0;
         dpl_ff        <= '0;
         held_phase_ff <= '0;
         held_lag_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
         updated_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         wr_pos_ff     <= wr_pos_in;
         ctl1_ff       <= ctl1_in;
         dpl_ff        <= dpl_in;
         held_phase_ff <= held_phase_in;
         held_lag_ff   <= held_lag_in;
         rsp_valid_ff  <= rsp_valid_in;
         updated_ff    <= updated_in;
      end
      k_ff       <= k_in;
      n_ff       <= n_in;
      lag_ff     <= lag_in;
      prod_ph_ff <= prod_ph_in;
   end

   cxpm_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (FRAME_LENGTH)
   ) u_frame_a (
      .clock (clock),
      .we    (accept),
      .waddr (wr_pos_ff),
      .wdata (req_sample_a),
      .raddr (k_ff),
      .rdata (a_rdata)
   );

   cxpm_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (FRAME_LENGTH)
   ) u_frame_b (
      .clock (clock),
      .we    (accept),
      .waddr (wr_pos_ff),
      .wdata (req_sample_b),
      .raddr (n_ff),
      .rdata (b_rdata)
   );

   cxpm_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .clear    (accept_last),
      .ctl      (ctl1_ff),
      .a_data   (a_rdata),
      .b_data   (b_rdata),
      .pending  (mac_pending),
      .best_idx (best_idx)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_phase_deg_q8  = held_phase_ff;
   assign rsp_phase_updated = updated_ff;
   assign rsp_peak_lag      = held_lag_ff;

   `CXPM_ASSERT(a_rsp_only_idle, clock, reset, rsp_valid |-> !busy, "result during a pass")
   `CXPM_ASSERT(a_frame_end_busy, clock, reset, accept_last |=> busy, "no pass after frame")
   `CXPM_ASSERT(a_lag_range, clock, reset, busy |-> lag_ff <= IDX_LAST, "lag out of range")
   `CXPM_ASSERT(a_issue_in_corr, clock, reset, ctl1_ff.valid |-> $past(busy), "stray product")
   `CXPM_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid, "strobe after reset")

endmodule

// ===== sv/cxpm_ram.sv =====
module cxpm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/cxpm_mac.sv =====
module cxpm_mac
   import cxpm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 clear,
   input  cxpm_mac_ctl_type     ctl,
   input  logic [SAMPLE_W-1:0]  a_data,
   input  logic [SAMPLE_W-1:0]  b_data,
   output logic                 pending,
   output logic [LAG_CNT_W-1:0] best_idx
);

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   cxpm_mac_ctl_type         ctl2_ff, ctl2_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [ACC_W-1:0]  best_ff, best_in;
   logic [LAG_CNT_W-1:0]     best_idx_ff, best_idx_in;
   logic signed [ACC_W-1:0]  sum;

   always_comb begin
      prod_in     = prod_ff;
      ctl2_in     = ctl;
      acc_in      = acc_ff;
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      sum         = acc_ff + ACC_W'(prod_ff);

      if (ctl.valid) begin
         prod_in = $signed(a_data) * $signed(b_data);
      end

      if (clear) begin
         acc_in      = '0;
         // The most negative value loses to any real correlation sum.
         best_in     = {1'b1, {(ACC_W-1){1'b0}}};
         best_idx_in = '0;
      end else if (ctl2_ff.valid) begin
         if (ctl2_ff.last) begin
            acc_in = '0;
            // Strictly greater keeps the lowest lag on ties.
            if (sum > best_ff) begin
               best_in     = sum;
               best_idx_in = ctl2_ff.lag_idx;
            end
         end else begin
            acc_in = sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl2_ff <= '0;
      end else begin
         ctl2_ff <= ctl2_in;
      end
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
   end

   assign pending  = ctl2_ff.valid;
   assign best_idx = best_idx_ff;

endmodule

// ===== verif/cross_correlation_phase_meter_tb.sv =====
module cross_correlation_phase_meter_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import cxpm_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int RANDOM_ITEMS = 800;
   localparam logic [DPL_W-1:0] DEG_STATED_MAX = 24'd11796480;
   localparam logic [DPL_W-1:0] DEG_ALL_ONES   = '1;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic               updated;
      logic [PEAK_W-1:0]  lag;
   } meter_reading_type;

   typedef enum {FRAME_NOISE, FRAME_IMPULSE, FRAME_SHIFTED, FRAME_FLAT} frame_shape_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [SAMPLE_W-1:0] req_sample_a = '0;
   logic [SAMPLE_W-1:0] req_sample_b = '0;
   logic                rsp_valid;
   logic [PHASE_W-1:0]  rsp_phase_deg_q8;
   logic                rsp_phase_updated;
   logic [PEAK_W-1:0]   rsp_peak_lag;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [DPL_W-1:0]    csr_wdata = '0;

   // Shadow copy of the block state used to predict each reading.
   logic signed [SAMPLE_W-1:0] shadow_a [FRAME_LENGTH];
   logic signed [SAMPLE_W-1:0] shadow_b [FRAME_LENGTH];
   int                         shadow_pos;
   logic signed [PHASE_W-1:0]  shadow_phase;
   int                         shadow_lag;
   logic [DPL_W-1:0]           shadow_deg_per_lag;

   meter_reading_type readings_due[$];
   meter_reading_type due;
   int             fail_count = 0;
   int             cycle_count = 0;
   bit             gaps_on = 1'b1;

   // Samples planned for the frame being sent.
   logic [SAMPLE_W-1:0] plan_a [FRAME_LENGTH];
   logic [SAMPLE_W-1:0] plan_b [FRAME_LENGTH];

   cross_correlation_phase_meter DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_sample_a      (req_sample_a),
      .req_sample_b      (req_sample_b),
      .rsp_valid         (rsp_valid),
      .rsp_phase_deg_q8  (rsp_phase_deg_q8),
      .rsp_phase_updated (rsp_phase_updated),
      .rsp_peak_lag      (rsp_peak_lag),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("cross_correlation_phase_meter_tb NOT OK");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      fail_count++;
   endtask

   // Stores one accepted item and, when it completes a frame, correlates both
   // frames over every lag and rescales the first peak to degrees.
   function automatic void accept_sample_pair(input logic [SAMPLE_W-1:0] a,
                                              input logic [SAMPLE_W-1:0] b);
      longint best;
      longint acc;
      longint prod;
      longint mag;
      longint q8;
      int     best_m;
      int     k;
      logic   updated;
      updated = 1'b0;
      shadow_a[shadow_pos] = a;
      shadow_b[shadow_pos] = b;
      shadow_pos++;
      if (shadow_pos >= FRAME_LENGTH) begin
         shadow_pos = 0;
         updated = 1'b1;
         best = 0;
         best_m = -(FRAME_LENGTH - 1);
         for (int m = -(FRAME_LENGTH - 1); m <= FRAME_LENGTH - 1; m++) begin
            acc = 0;
            for (int n = 0; n < FRAME_LENGTH; n++) begin
               k = n + m;
               if (k >= 0 && k < FRAME_LENGTH)
                  acc += longint'(shadow_a[k]) * longint'(shadow_b[n]);
            end
            if (m == -(FRAME_LENGTH - 1) || acc > best) begin
               best = acc;
               best_m = m;
            end
         end
         shadow_lag = best_m;
         prod = longint'(best_m) * longint'({40'd0, shadow_deg_per_lag});
         // Q16 to Q8, rounding half away from zero.
         mag = (prod < 0) ? -prod : prod;
         mag = (mag + 128) >> 8;
         q8 = (prod < 0) ? -mag : mag;
         if (q8 > longint'(32'sh7fffffff))
            q8 = longint'(32'sh7fffffff);
         if (q8 < -longint'(64'sd2147483648))
            q8 = -longint'(64'sd2147483648);
         shadow_phase = q8[PHASE_W-1:0];
      end
      readings_due.push_back('{phase: shadow_phase, updated: updated,
                               lag: shadow_lag[PEAK_W-1:0]});
   endfunction

   task automatic send_item(input logic [SAMPLE_W-1:0] a, input logic [SAMPLE_W-1:0] b);
      int gap;
      int roll;
      start <= 1'b1;
      req_sample_a <= a;
      req_sample_b <= b;
      do @(posedge clock); while (busy);
      accept_sample_pair(a, b);
      if ($urandom_range(0, 49) == 0)
         gaps_on = !gaps_on;
      gap = 0;
      if (gaps_on) begin
         roll = $urandom_range(0, 99);
         if (roll >= 90)
            gap = $urandom_range(10, 40);
         else if (roll >= 55)
            gap = $urandom_range(1, 3);
      end
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_until_idle();
      start <= 1'b0;
      while (readings_due.size() != 0 || busy)
         @(posedge clock);
   endtask

   task automatic write_degrees_per_lag(input logic [DPL_W-1:0] value);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      shadow_deg_per_lag = value;
   endtask

   function automatic logic [SAMPLE_W-1:0] quiet_sample();
      return SAMPLE_W'(int'($urandom_range(0, 15)) - 8);
   endfunction

   function automatic void plan_frame(input frame_shape_type shape, input int lag);
      int nb;
      int lo;
      int hi;
      int d;
      logic [SAMPLE_W-1:0] ca;
      logic [SAMPLE_W-1:0] cb;
      case (shape)
         FRAME_IMPULSE: begin
            // Two strong same-sign pulses over low noise put the peak at lag.
            for (int n = 0; n < FRAME_LENGTH; n++) begin
               plan_a[n] = quiet_sample();
               plan_b[n] = quiet_sample();
            end
            lo = (lag < 0) ? -lag : 0;
            hi = (lag > 0) ? FRAME_LENGTH - 1 - lag : FRAME_LENGTH - 1;
            nb = $urandom_range(lo, hi);
            if ($urandom_range(0, 1)) begin
               plan_a[nb + lag] = SAMPLE_W'($urandom_range(16384, 32767));
               plan_b[nb] = SAMPLE_W'($urandom_range(16384, 32767));
            end else begin
               plan_a[nb + lag] = SAMPLE_W'(-int'($urandom_range(16384, 32768)));
               plan_b[nb] = SAMPLE_W'(-int'($urandom_range(16384, 32768)));
            end
         end
         FRAME_SHIFTED: begin
            d = int'($urandom_range(0, 128)) - 64;
            for (int n = 0; n < FRAME_LENGTH; n++)
               plan_a[n] = SAMPLE_W'($urandom);
            for (int n = 0; n < FRAME_LENGTH; n++)
               plan_b[n] = plan_a[(n + d + FRAME_LENGTH) % FRAME_LENGTH];
         end
         FRAME_FLAT: begin
            // Constant frames of opposite sign tie at the edges, and tie everywhere when either is zero.
            ca = ($urandom_range(0, 2) == 0) ? '0 : SAMPLE_W'($urandom);
            cb = ($urandom_range(0, 2) == 0) ? '0 : SAMPLE_W'($urandom);
            for (int n = 0; n < FRAME_LENGTH; n++) begin
               plan_a[n] = ca;
               plan_b[n] = cb;
            end
         end
         default: begin
            for (int n = 0; n < FRAME_LENGTH; n++) begin
               plan_a[n] = SAMPLE_W'($urandom);
               plan_b[n] = SAMPLE_W'($urandom);
            end
         end
      endcase
   endfunction

   task automatic test_sample_extremes();
      logic [SAMPLE_W-1:0] da [16];
      logic [SAMPLE_W-1:0] db [16];
      da = '{16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001, 16'hffff,
             16'h5555, 16'haaaa, 16'h8000, 16'h0000, 16'h0001, 16'h7fff, 16'h8001, 16'h0000};
      db = '{16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h0000, 16'h0001, 16'hffff, 16'hffff,
             16'haaaa, 16'h5555, 16'h0000, 16'h7fff, 16'h8000, 16'h0000, 16'h7ffe, 16'h8000};
      write_degrees_per_lag('0);
      for (int i = 0; i < 16; i++)
         send_item(da[i], db[i]);
   endtask

   task automatic test_random_frames();
      int              sent;
      int              frame_no;
      int              lag;
      frame_shape_type shape;
      sent = 0;
      frame_no = 0;
      plan_frame(FRAME_NOISE, 0);
      while (sent < RANDOM_ITEMS) begin
         if (shadow_pos == 0) begin
            frame_no++;
            wait_until_idle();
            case (frame_no)
               1: write_degrees_per_lag(DEG_ALL_ONES);
               2: write_degrees_per_lag(DEG_STATED_MAX);
               default: begin
                  case ($urandom_range(0, 3))
                     0: write_degrees_per_lag('0);
                     1: write_degrees_per_lag(DEG_STATED_MAX);
                     2: write_degrees_per_lag(DEG_ALL_ONES);
                     default: write_degrees_per_lag(DPL_W'($urandom_range(0, DEG_STATED_MAX)));
                  endcase
               end
            endcase
            if ($urandom_range(0, 3) == 0 || frame_no == 1)
               lag = $urandom_range(0, 1) ? FRAME_LENGTH - 1 : -(FRAME_LENGTH - 1);
            else
               lag = int'($urandom_range(0, 2 * FRAME_LENGTH - 2)) - (FRAME_LENGTH - 1);
            if (frame_no == 1)
               shape = FRAME_IMPULSE;
            else
               shape = frame_shape_type'($urandom_range(0, 3));
            plan_frame(shape, lag);
         end
         send_item(plan_a[shadow_pos], plan_b[shadow_pos]);
         sent++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (readings_due.size() == 0) begin
            report_mismatch("reading with none due", rsp_phase_deg_q8, '0);
         end else begin
            due = readings_due.pop_front();
            if (rsp_phase_deg_q8 !== due.phase)
               report_mismatch("phase_deg_q8", rsp_phase_deg_q8, due.phase);
            if (rsp_phase_updated !== due.updated)
               report_mismatch("phase_updated", 32'(rsp_phase_updated), 32'(due.updated));
            if (rsp_peak_lag !== due.lag)
               report_mismatch("peak_lag", 32'(rsp_peak_lag), 32'(due.lag));
         end
      end
   end

   initial begin
      shadow_pos = 0;
      shadow_phase = '0;
      shadow_lag = 0;
      shadow_deg_per_lag = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_sample_extremes();
      test_random_frames();
      wait_until_idle();
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("cross_correlation_phase_meter_tb OK");
      else
         $display("cross_correlation_phase_meter_tb NOT OK");
      $finish;
   end

endmodule
